### sv/kn_pkg.sv
package kn_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int IDX_W     = $clog2(MAX_ITEMS);
	localparam int DIMS      = 4;
	localparam int COMP_W    = 16;
	localparam int VEC_W     = 64;
	localparam int ID_W      = 16;
	localparam int DIST_W    = 32;
	localparam int KEY_W     = DIST_W + ID_W;
	localparam int CELLS     = 64;
	localparam int CNT_W     = 7;
	localparam int ROOT_W    = 25;
	localparam int SQ_IN_W   = 2 * ROOT_W;
	localparam int REM_W     = ROOT_W + 2;
	localparam int DEN_W     = 2 * ROOT_W;
	localparam int DIV_W     = DEN_W + 1;
	localparam int QUO_W     = 16;
	localparam int IN_W      = 88;
	localparam int OUT_W     = 48;
	localparam int ENTRY_W   = ID_W + VEC_W;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_FULL   = 2'd1;
	localparam logic [1:0] STAT_NONE   = 2'd2;
	localparam logic [1:0] STAT_ABSENT = 2'd3;

	localparam logic [1:0] MET_EUC = 2'd0;
	localparam logic [1:0] MET_COS = 2'd1;
	localparam logic [1:0] MET_MAN = 2'd2;

	localparam logic [DIST_W-1:0] ONE_Q16 = 32'd65536;

	typedef logic [KEY_W-1:0] key_t;

	typedef struct packed {
		logic live;
		logic hit;
		logic last;
	} kn_tag_t;

	typedef struct packed {
		logic clear;
		logic ins;
		logic shift;
	} kn_ctrl_t;

endpackage

### sv/kn_ram.sv
module kn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### sv/kn_cell.sv
module kn_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  kn_pkg::kn_ctrl_t ctrl,
	input  kn_pkg::key_t    cand,
	input  kn_pkg::key_t    left_key,
	input  logic            left_valid,
	input  logic            left_lt,
	input  kn_pkg::key_t    right_key,
	input  logic            right_valid,
	output kn_pkg::key_t    key,
	output logic            valid,
	output logic            lt
);

	kn_pkg::key_t key_q;
	logic         valid_q;

	assign key   = key_q;
	assign valid = valid_q;
	assign lt    = ctrl.ins && (!valid_q || (cand < key_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= right_valid;
		end else if (ctrl.ins) begin
			if (left_lt) begin
				valid_q <= left_valid;
			end else if (lt) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			key_q <= right_key;
		end else if (ctrl.ins) begin
			if (left_lt) begin
				key_q <= left_key;
			end else if (lt) begin
				key_q <= cand;
			end
		end
	end

endmodule

### sv/kn_dist.sv
module kn_dist (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [1:0]                 mode,
	input  logic [kn_pkg::VEC_W-1:0]   q_vec,
	input  kn_pkg::kn_tag_t            in_tag,
	input  logic [kn_pkg::ID_W-1:0]    in_id,
	input  logic [kn_pkg::VEC_W-1:0]   in_vec,
	output kn_pkg::kn_tag_t            out_tag,
	output logic [kn_pkg::ID_W-1:0]    out_id,
	output logic [kn_pkg::DIST_W-1:0]  out_dist
);

	localparam int D  = kn_pkg::DIMS;
	localparam int RW = kn_pkg::ROOT_W;
	localparam int XW = kn_pkg::SQ_IN_W;
	localparam int MW = kn_pkg::REM_W;
	localparam int NW = kn_pkg::DEN_W;
	localparam int VW = kn_pkg::DIV_W;
	localparam int QW = kn_pkg::QUO_W;

	typedef struct packed {
		kn_pkg::kn_tag_t          tag;
		logic [kn_pkg::ID_W-1:0]  id;
		logic                     neg;
		logic                     zero;
		logic [32:0]              mag;
		logic [17:0]              man;
	} carry_t;

	logic signed [15:0] qa [D];
	logic signed [15:0] vb [D];

	logic signed [16:0] diff_s1 [D];
	logic signed [31:0] ab_s1 [D];
	logic signed [31:0] aa_s1 [D];
	logic signed [31:0] bb_s1 [D];
	kn_pkg::kn_tag_t    tag_s1;
	logic [15:0]        id_s1;

	logic signed [16:0] abs_c [D];
	logic signed [33:0] dot_c;
	logic [32:0]        na_c;
	logic [32:0]        nb_c;
	logic [17:0]        man_c;

	logic signed [33:0] dd_s2 [D];
	logic signed [33:0] dot_s2;
	logic [32:0]        na_s2;
	logic [32:0]        nb_s2;
	logic [17:0]        man_s2;
	kn_pkg::kn_tag_t    tag_s2;
	logic [15:0]        id_s2;

	logic [34:0]        sq_c;
	logic [34:0]        sq_s3;
	logic signed [33:0] dot_s3;
	logic [32:0]        na_s3;
	logic [32:0]        nb_s3;
	logic [17:0]        man_s3;
	kn_pkg::kn_tag_t    tag_s3;
	logic [15:0]        id_s3;

	logic [XW-1:0] xa_p [RW+1];
	logic [XW-1:0] xb_p [RW+1];
	logic [RW-1:0] ra_p [RW+1];
	logic [RW-1:0] rb_p [RW+1];
	logic [MW-1:0] ma_p [RW+1];
	logic [MW-1:0] mb_p [RW+1];
	carry_t        cs_p [RW+1];

	logic [NW-1:0] den_m;
	logic [RW-1:0] ea_m;
	carry_t        c_m;

	logic [VW-1:0] rem_p [QW+1];
	logic [QW-1:0] quo_p [QW+1];
	logic [NW-1:0] den_p [QW+1];
	logic [RW-1:0] ea_p  [QW+1];
	logic          big_p [QW+1];
	carry_t        cd_p  [QW+1];

	logic [31:0] s_c;
	logic [31:0] cos_c;
	logic [31:0] dist_c;
	carry_t      cf;

	always_comb begin
		for (int d = 0; d < D; d++) begin
			qa[d] = q_vec[d*16 +: 16];
			vb[d] = in_vec[d*16 +: 16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s1 <= in_tag;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		id_s1 <= in_id;
		for (int d = 0; d < D; d++) begin
			diff_s1[d] <= {qa[d][15], qa[d]} - {vb[d][15], vb[d]};
			ab_s1[d]   <= qa[d] * vb[d];
			aa_s1[d]   <= qa[d] * qa[d];
			bb_s1[d]   <= vb[d] * vb[d];
		end
	end

	always_comb begin
		dot_c = '0;
		na_c  = '0;
		nb_c  = '0;
		man_c = '0;
		for (int d = 0; d < D; d++) begin
			abs_c[d] = diff_s1[d][16] ? 17'(-diff_s1[d]) : diff_s1[d];
			dot_c    = dot_c + 34'(ab_s1[d]);
			na_c     = na_c + 33'(aa_s1[d][30:0]);
			nb_c     = nb_c + 33'(bb_s1[d][30:0]);
			man_c    = man_c + 18'(abs_c[d][15:0]);
		end
	end

	always_ff @(posedge clk) begin
		id_s2  <= id_s1;
		dot_s2 <= dot_c;
		na_s2  <= na_c;
		nb_s2  <= nb_c;
		man_s2 <= man_c;
		for (int d = 0; d < D; d++) begin
			dd_s2[d] <= diff_s1[d] * diff_s1[d];
		end
	end

	always_comb begin
		sq_c = '0;
		for (int d = 0; d < D; d++) begin
			sq_c = sq_c + 35'(dd_s2[d][32:0]);
		end
	end

	always_ff @(posedge clk) begin
		id_s3  <= id_s2;
		sq_s3  <= sq_c;
		dot_s3 <= dot_s2;
		na_s3  <= na_s2;
		nb_s3  <= nb_s2;
		man_s3 <= man_s2;
	end

	always_comb begin
		xa_p[0] = (mode == kn_pkg::MET_COS) ? {1'b0, na_s3, 16'b0} : {7'b0, sq_s3, 8'b0};
		xb_p[0] = {1'b0, nb_s3, 16'b0};
		ra_p[0] = '0;
		rb_p[0] = '0;
		ma_p[0] = '0;
		mb_p[0] = '0;
		cs_p[0].tag  = tag_s3;
		cs_p[0].id   = id_s3;
		cs_p[0].neg  = dot_s3[33];
		cs_p[0].zero = (na_s3 == '0) || (nb_s3 == '0);
		cs_p[0].mag  = dot_s3[33] ? 33'(-dot_s3) : dot_s3[32:0];
		cs_p[0].man  = man_s3;
	end

	for (genvar j = 0; j < RW; j++) begin : g_sqrt
		logic [MW-1:0] sha, shb, tra, trb;
		logic          gea, geb;
		assign sha = {ma_p[j][MW-3:0], xa_p[j][XW-1 -: 2]};
		assign shb = {mb_p[j][MW-3:0], xb_p[j][XW-1 -: 2]};
		assign tra = {ra_p[j], 2'b01};
		assign trb = {rb_p[j], 2'b01};
		assign gea = sha >= tra;
		assign geb = shb >= trb;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cs_p[j+1] <= '0;
			end else begin
				cs_p[j+1] <= cs_p[j];
			end
		end

		always_ff @(posedge clk) begin
			xa_p[j+1] <= {xa_p[j][XW-3:0], 2'b00};
			xb_p[j+1] <= {xb_p[j][XW-3:0], 2'b00};
			ra_p[j+1] <= {ra_p[j][RW-2:0], gea};
			rb_p[j+1] <= {rb_p[j][RW-2:0], geb};
			ma_p[j+1] <= gea ? sha - tra : sha;
			mb_p[j+1] <= geb ? shb - trb : shb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_m      <= '0;
			cd_p[0]  <= '0;
		end else begin
			c_m      <= cs_p[RW];
			cd_p[0]  <= c_m;
		end
	end

	always_ff @(posedge clk) begin
		den_m    <= ra_p[RW] * rb_p[RW];
		ea_m     <= ra_p[RW];
		den_p[0] <= den_m;
		ea_p[0]  <= ea_m;
		rem_p[0] <= {2'b00, c_m.mag, 16'b0};
		quo_p[0] <= '0;
		big_p[0] <= {1'b0, c_m.mag, 16'b0} >= den_m;
	end

	for (genvar j = 0; j < QW; j++) begin : g_div
		logic [VW-1:0] sh;
		logic          ge;
		assign sh = {rem_p[j][VW-2:0], 1'b0};
		assign ge = sh >= {1'b0, den_p[j]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cd_p[j+1] <= '0;
			end else begin
				cd_p[j+1] <= cd_p[j];
			end
		end

		always_ff @(posedge clk) begin
			rem_p[j+1] <= ge ? sh - {1'b0, den_p[j]} : sh;
			quo_p[j+1] <= {quo_p[j][QW-2:0], ge};
			den_p[j+1] <= den_p[j];
			ea_p[j+1]  <= ea_p[j];
			big_p[j+1] <= big_p[j];
		end
	end

	assign cf = cd_p[QW];

	always_comb begin
		s_c   = big_p[QW] ? kn_pkg::ONE_Q16 : {16'b0, quo_p[QW]};
		cos_c = cf.zero ? kn_pkg::ONE_Q16 :
			(cf.neg ? kn_pkg::ONE_Q16 + s_c : kn_pkg::ONE_Q16 - s_c);
		case (mode)
			kn_pkg::MET_COS: dist_c = cos_c;
			kn_pkg::MET_MAN: dist_c = {10'b0, cf.man, 4'b0};
			default:         dist_c = {7'b0, ea_p[QW]};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_tag <= '0;
		end else begin
			out_tag <= cf.tag;
		end
	end

	always_ff @(posedge clk) begin
		out_id   <= cf.id;
		out_dist <= dist_c;
	end

endmodule

### sv/brute_force_knn_search.sv
// Insert: one slot checked per cycle until a free one is found.
// Remove: one stored id read from the slot memory per cycle.
// Query: every slot is read into the distance pipeline, then the reported neighbors
// leave the sorting cell row one at a time, each waiting while the output is stalled.
// One operation at a time; results leave through an output register.
// Reset (async, active low) clears all slot valid bits, the cell row and metric_mode.
module brute_force_knn_search (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,  // item_id, component_0..3, neighbor_count, zero pad
	input  logic [1:0]  s_tuser,  // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // hit_id, hit_distance
	output logic [1:0]  m_tuser,  // status
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data  // metric_mode
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_INS   = 3'd1;
	localparam logic [2:0] S_REM   = 3'd2;
	localparam logic [2:0] S_REMW  = 3'd3;
	localparam logic [2:0] S_QRY   = 3'd4;
	localparam logic [2:0] S_QWAIT = 3'd5;
	localparam logic [2:0] S_DRAIN = 3'd6;
	localparam logic [2:0] S_RESP  = 3'd7;

	localparam int IW = kn_pkg::IDX_W;
	localparam int NC = kn_pkg::CELLS;

	logic [2:0]                        state_q;
	logic [IW-1:0]                     idx_q;
	logic [kn_pkg::MAX_ITEMS-1:0]      slot_valid_q;
	logic [1:0]                        mode_q;
	logic [1:0]                        status_q;
	logic                              hit_q;
	logic [kn_pkg::CNT_W-1:0]          k_q;
	logic [kn_pkg::CNT_W-1:0]          n_q;
	logic [kn_pkg::ID_W-1:0]           id_q;
	logic [kn_pkg::VEC_W-1:0]          qvec_q;

	logic                              iss_live_s1;
	logic                              iss_last_s1;
	logic                              iss_qry_s1;
	logic [IW-1:0]                     iss_idx_s1;

	logic                              out_valid_q;
	logic [kn_pkg::OUT_W-1:0]          out_data_q;
	logic [1:0]                        out_user_q;
	logic                              out_last_q;

	logic                              accept;
	logic                              slot_free;
	logic                              issue;
	logic                              ram_we;
	logic [kn_pkg::ENTRY_W-1:0]        ram_rdata;
	logic                              match_s1;
	logic                              emit;
	logic [1:0]                        emit_user;
	logic [kn_pkg::OUT_W-1:0]          emit_data;
	logic                              emit_last;
	logic                              empty_reply;
	logic                              final_hit;

	kn_pkg::kn_tag_t                   dtag_in;
	kn_pkg::kn_tag_t                   dtag_out;
	logic [kn_pkg::ID_W-1:0]           did_out;
	logic [kn_pkg::DIST_W-1:0]         ddist_out;

	kn_pkg::kn_ctrl_t                  ctrl;
	kn_pkg::key_t                      cand;
	kn_pkg::key_t                      ckey [NC];
	logic                              cvalid [NC];
	logic                              clt [NC];

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;
	assign slot_free = !out_valid_q || m_tready;
	assign issue     = (state_q == S_REM) || (state_q == S_QRY);
	assign ram_we    = (state_q == S_INS) && !slot_valid_q[idx_q];
	assign match_s1  = iss_live_s1 && !iss_qry_s1 && slot_valid_q[iss_idx_s1] &&
		(ram_rdata[kn_pkg::ID_W-1:0] == id_q);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

	kn_ram #(.WIDTH(kn_pkg::ENTRY_W), .DEPTH(kn_pkg::MAX_ITEMS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata ({qvec_q, id_q}),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	assign dtag_in.live = iss_live_s1 && iss_qry_s1;
	assign dtag_in.hit  = slot_valid_q[iss_idx_s1];
	assign dtag_in.last = iss_last_s1;

	kn_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.mode     (mode_q),
		.q_vec    (qvec_q),
		.in_tag   (dtag_in),
		.in_id    (ram_rdata[kn_pkg::ID_W-1:0]),
		.in_vec   (ram_rdata[kn_pkg::ENTRY_W-1:kn_pkg::ID_W]),
		.out_tag  (dtag_out),
		.out_id   (did_out),
		.out_dist (ddist_out)
	);

	assign empty_reply = (n_q == '0) && ((k_q == '0) || !cvalid[0]);
	assign final_hit   = ((n_q + 7'd1) == k_q) || !cvalid[1];

	always_comb begin
		emit      = 1'b0;
		emit_user = kn_pkg::STAT_OK;
		emit_data = '0;
		emit_last = 1'b1;
		if (slot_free) begin
			if (state_q == S_RESP) begin
				emit      = 1'b1;
				emit_user = status_q;
			end else if (state_q == S_DRAIN) begin
				emit = 1'b1;
				if (empty_reply) begin
					emit_user = kn_pkg::STAT_NONE;
				end else begin
					emit_data = {ckey[0][kn_pkg::KEY_W-1:kn_pkg::ID_W],
						ckey[0][kn_pkg::ID_W-1:0]};
					emit_last = final_hit;
				end
			end
		end
	end

	assign ctrl.clear = accept && (s_tuser != kn_pkg::OP_INSERT) &&
		(s_tuser != kn_pkg::OP_REMOVE);
	assign ctrl.ins   = dtag_out.live && dtag_out.hit;
	assign ctrl.shift = emit && (state_q == S_DRAIN) && !empty_reply;
	assign cand       = {ddist_out, did_out};

	for (genvar i = 0; i < NC; i++) begin : g_cell
		kn_pkg::key_t lkey, rkey;
		logic         lval, llt, rval;
		if (i == 0) begin : g_first
			assign lkey = '0;
			assign lval = 1'b0;
			assign llt  = 1'b0;
		end else begin : g_mid
			assign lkey = ckey[i-1];
			assign lval = cvalid[i-1];
			assign llt  = clt[i-1];
		end
		if (i == NC - 1) begin : g_end
			assign rkey = '0;
			assign rval = 1'b0;
		end else begin : g_inner
			assign rkey = ckey[i+1];
			assign rval = cvalid[i+1];
		end
		kn_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.cand        (cand),
			.left_key    (lkey),
			.left_valid  (lval),
			.left_lt     (llt),
			.right_key   (rkey),
			.right_valid (rval),
			.key         (ckey[i]),
			.valid       (cvalid[i]),
			.lt          (clt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			slot_valid_q <= '0;
			mode_q       <= '0;
			status_q     <= kn_pkg::STAT_OK;
			hit_q        <= 1'b0;
			n_q          <= '0;
			iss_live_s1  <= 1'b0;
			iss_last_s1  <= 1'b0;
			iss_qry_s1   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q <= cfg_data;
			end
			iss_live_s1 <= issue;
			iss_last_s1 <= issue && (idx_q == IW'(kn_pkg::MAX_ITEMS - 1));
			iss_qry_s1  <= (state_q == S_QRY);
			if (match_s1) begin
				slot_valid_q[iss_idx_s1] <= 1'b0;
				hit_q <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						hit_q <= 1'b0;
						n_q   <= '0;
						case (s_tuser)
							kn_pkg::OP_INSERT: state_q <= S_INS;
							kn_pkg::OP_REMOVE: state_q <= S_REM;
							default:           state_q <= S_QRY;
						endcase
					end
				end
				S_INS: begin
					if (!slot_valid_q[idx_q]) begin
						slot_valid_q[idx_q] <= 1'b1;
						status_q <= kn_pkg::STAT_OK;
						state_q  <= S_RESP;
					end else if (idx_q == IW'(kn_pkg::MAX_ITEMS - 1)) begin
						status_q <= kn_pkg::STAT_FULL;
						state_q  <= S_RESP;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_REM, S_QRY: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == IW'(kn_pkg::MAX_ITEMS - 1)) begin
						state_q <= (state_q == S_REM) ? S_REMW : S_QWAIT;
					end
				end
				S_REMW: begin
					if (iss_live_s1 && iss_last_s1) begin
						status_q <= (hit_q || match_s1) ? kn_pkg::STAT_OK : kn_pkg::STAT_ABSENT;
						state_q  <= S_RESP;
					end
				end
				S_QWAIT: begin
					if (dtag_out.live && dtag_out.last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (emit) begin
						n_q <= n_q + 1'b1;
						if (emit_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_RESP: begin
					if (emit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		iss_idx_s1 <= idx_q;
		if (accept) begin
			id_q   <= s_tdata[15:0];
			qvec_q <= s_tdata[79:16];
			k_q    <= s_tdata[86:80];
		end
		if (emit) begin
			out_data_q <= emit_data;
			out_user_q <= emit_user;
			out_last_q <= emit_last;
		end
	end

endmodule

### sv/kn_check.sv
module kn_check (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [87:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [1:0]  cfg_data
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
		$stable(m_tlast))
		else $error("result changed while stalled");

	a_fail_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != kn_pkg::STAT_OK) |-> m_tlast)
		else $error("non-ok result not marked last");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != kn_pkg::STAT_OK) |-> (m_tdata == '0))
		else $error("non-ok result carries data");

endmodule

bind brute_force_knn_search kn_check u_kn_check (.*);
